[rtl/kps_pkg.sv]
// Shared types, codes and constants of the keyframe playback sampler.
`default_nettype none

package kps_pkg;

    // Item operation codes.
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_SAMPLE = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_PLAY   = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_COUNT = 2'd0;
    localparam logic [1:0] REG_LOOP      = 2'd1;

    // Divider geometry and fixed-point constants.
    localparam int         DIV_STEPS = 48;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic [14:0] LOOK_ONE  = 15'd16384;

    // One keyframe as held in the table.
    typedef struct packed {
        logic        [31:0] tm;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] lz;
        logic signed [15:0] roll;
        logic        [15:0] fov;
    } kps_key_t;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic        start;
        logic [47:0] numer;
        logic [31:0] denom;
    } kps_div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quot;
        logic [31:0] rem;
    } kps_div_rsp_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_SCAN, ST_TICK, ST_MODW, ST_SMP0, ST_SMP1, ST_SMP2,
        ST_BS, ST_BSW, ST_RA, ST_RB, ST_RBW, ST_ALPHA, ST_ALW, ST_LMUL,
        ST_LADD, ST_SQMUL, ST_SQADD, ST_NCHK, ST_SQRT, ST_LDIV, ST_LDW,
        ST_DONE
    } kps_state_t;

endpackage

`default_nettype wire

[rtl/kps_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module kps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/kps_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the sampler.
`default_nettype none

module kps_div (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire kps_pkg::kps_div_req_t req,
    output kps_pkg::kps_div_rsp_t     rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;

    // One shift-and-subtract step per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[47]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'(kps_pkg::DIV_STEPS);
            q_next    = req.numer;
            r_next    = '0;
            d_next    = req.denom;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = 32'(trial - {1'b0, d_reg});
                q_next = {q_reg[46:0], 1'b1};
            end else begin
                r_next = trial[31:0];
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

endmodule

`default_nettype wire

[rtl/keyframe_playback_sampler.sv]
// Top level of the camera keyframe playback sampler.
// A key write finishes in the cycle it is accepted; the block is ready again the next cycle.
// A sample runs a binary search of at most log2(keys) + 1 steps, a division for alpha,
// the lerps, the squared length, the square root and a division per look component to
// renormalize; a tick first scans the keys and divides once more when the time wraps.
// The divider, the single multiplier and a result not yet taken set how long these take. Reset
// clears time, play state, registers and the result slot; the key table is not cleared.
`default_nettype none

module keyframe_playback_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_opcode,
    input  wire logic [5:0]         s_key_index,
    input  wire logic [31:0]        s_time_value,
    input  wire logic signed [31:0] s_pos_x,
    input  wire logic signed [31:0] s_pos_y,
    input  wire logic signed [31:0] s_pos_z,
    input  wire logic signed [15:0] s_look_x,
    input  wire logic signed [15:0] s_look_y,
    input  wire logic signed [15:0] s_look_z,
    input  wire logic signed [15:0] s_roll_angle,
    input  wire logic [15:0]        s_view_angle,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_out_pos_x,
    output logic signed [31:0]      m_out_pos_y,
    output logic signed [31:0]      m_out_pos_z,
    output logic signed [15:0]      m_out_look_x,
    output logic signed [15:0]      m_out_look_y,
    output logic signed [15:0]      m_out_look_z,
    output logic signed [15:0]      m_out_roll,
    output logic [15:0]             m_out_fov,
    output logic [31:0]             m_play_time,
    output logic                    m_is_playing,
    output logic                    m_has_keys
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int KW = $bits(kps_pkg::kps_key_t);

    kps_pkg::kps_state_t state_reg, state_next;

    logic [31:0]      cur_reg, cur_next;
    logic             playing_reg, playing_next;
    logic [6:0]       key_count_reg;
    logic             loop_reg;
    logic [31:0]      tv_reg, tv_next;
    logic [31:0]      st_reg, st_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             scan_vld_reg, scan_vld_next;
    logic [31:0]      end_reg, end_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    mid_reg, mid_next;
    kps_pkg::kps_key_t ka_reg, ka_next;
    kps_pkg::kps_key_t kb_reg, kb_next;
    logic [16:0]      alpha_reg, alpha_next;
    logic [2:0]       j_reg, j_next;
    logic signed [51:0] prod_reg, prod_next;
    logic signed [17:0] lk_reg [3];
    logic signed [17:0] lk_next [3];
    logic [35:0]      acc_reg, acc_next;
    logic [63:0]      sv_reg, sv_next;
    logic [63:0]      sres_reg, sres_next;
    logic [63:0]      sbit_reg, sbit_next;
    logic signed [31:0] rp_reg [3];
    logic signed [31:0] rp_next [3];
    logic signed [15:0] rl_reg [3];
    logic signed [15:0] rl_next [3];
    logic signed [15:0] rr_reg, rr_next;
    logic [15:0]      rf_reg, rf_next;
    logic             hk_reg, hk_next;
    logic             m_valid_reg, m_valid_next;
    logic             load_out;

    // Table and shared units.
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [KW-1:0]    ram_wdata, ram_rdata;
    kps_pkg::kps_key_t rd;
    kps_pkg::kps_div_req_t div_req;
    kps_pkg::kps_div_rsp_t div_rsp;

    // Helper values shared by the sequencer blocks.
    logic [CW-1:0]    n_keys;
    logic [CW:0]      lohi;
    logic [31:0]      cur_c;
    logic [32:0]      tick_sum;
    logic signed [33:0] a_sel, b_sel, diff;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] mul_p;
    logic signed [51:0] lerp_q, lerp_sum;
    logic [17:0]      mag;
    logic [14:0]      qc;
    logic [63:0]      sq_trial;
    logic             emit_first, emit_last, tick_wrap;

    kps_ram #(
        .WIDTH (KW),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign rd        = kps_pkg::kps_key_t'(ram_rdata);
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == kps_pkg::ST_IDLE);
    assign load_out  = (state_reg == kps_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    // Derived values used by both the state and the datapath logic.
    assign n_keys     = (32'(key_count_reg) > 32'(MAX_KEYS)) ? CW'(MAX_KEYS)
                                                             : CW'(key_count_reg);
    assign lohi       = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign cur_c      = (cur_reg > end_reg) ? end_reg : cur_reg;
    assign tick_sum   = {1'b0, cur_c} + {1'b0, tv_reg};
    assign tick_wrap  = playing_reg && (end_reg != 32'd0) && (tick_sum >= {1'b0, end_reg})
                        && loop_reg;
    assign emit_first = (n_keys == CW'(1)) || (st_reg <= rd.tm);
    assign emit_last  = (st_reg >= rd.tm);
    assign sq_trial   = sres_reg + sbit_reg;

    // Lerp operand selection by component.
    always_comb begin
        unique case (j_reg)
            3'd0: begin a_sel = 34'(ka_reg.px);   b_sel = 34'(kb_reg.px);   end
            3'd1: begin a_sel = 34'(ka_reg.py);   b_sel = 34'(kb_reg.py);   end
            3'd2: begin a_sel = 34'(ka_reg.pz);   b_sel = 34'(kb_reg.pz);   end
            3'd3: begin a_sel = 34'(ka_reg.lx);   b_sel = 34'(kb_reg.lx);   end
            3'd4: begin a_sel = 34'(ka_reg.ly);   b_sel = 34'(kb_reg.ly);   end
            3'd5: begin a_sel = 34'(ka_reg.lz);   b_sel = 34'(kb_reg.lz);   end
            3'd6: begin a_sel = 34'(ka_reg.roll); b_sel = 34'(kb_reg.roll); end
            default: begin
                a_sel = $signed({18'd0, ka_reg.fov});
                b_sel = $signed({18'd0, kb_reg.fov});
            end
        endcase
        diff = b_sel - a_sel;
    end

    // The single multiplier, shared by the lerps and the squared length.
    always_comb begin
        if (state_reg == kps_pkg::ST_SQMUL) begin
            mul_a = 34'(lk_reg[j_reg[1:0]]);
            mul_b = lk_reg[j_reg[1:0]];
        end else begin
            mul_a = diff;
            mul_b = $signed({1'b0, alpha_reg});
        end
        mul_p    = mul_a * mul_b;
        lerp_q   = prod_reg >>> 16;
        lerp_sum = 52'(a_sel) + lerp_q;
        mag      = lk_reg[j_reg[1:0]][17] ? 18'(-lk_reg[j_reg[1:0]])
                                          : 18'(lk_reg[j_reg[1:0]]);
        qc       = (div_rsp.quot > 48'(kps_pkg::LOOK_ONE)) ? kps_pkg::LOOK_ONE
                                                           : div_rsp.quot[14:0];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kps_pkg::ST_IDLE: begin
                if (s_valid) begin
                    priority case (s_opcode)
                        kps_pkg::OP_SAMPLE, kps_pkg::OP_PLAY, kps_pkg::OP_STOP:
                            state_next = kps_pkg::ST_SMP0;
                        kps_pkg::OP_TICK: state_next = kps_pkg::ST_SCAN;
                        default: state_next = kps_pkg::ST_IDLE;
                    endcase
                end
            end
            kps_pkg::ST_SCAN: begin
                if (idx_reg == n_keys && !scan_vld_reg) state_next = kps_pkg::ST_TICK;
            end
            kps_pkg::ST_TICK: begin
                state_next = tick_wrap ? kps_pkg::ST_MODW : kps_pkg::ST_SMP0;
            end
            kps_pkg::ST_MODW: begin
                if (div_rsp.done) state_next = kps_pkg::ST_SMP0;
            end
            kps_pkg::ST_SMP0: begin
                state_next = (n_keys == '0) ? kps_pkg::ST_DONE : kps_pkg::ST_SMP1;
            end
            kps_pkg::ST_SMP1: begin
                state_next = emit_first ? kps_pkg::ST_DONE : kps_pkg::ST_SMP2;
            end
            kps_pkg::ST_SMP2: begin
                state_next = emit_last ? kps_pkg::ST_DONE : kps_pkg::ST_BS;
            end
            kps_pkg::ST_BS: begin
                state_next = (lo_reg < hi_reg) ? kps_pkg::ST_BSW : kps_pkg::ST_RA;
            end
            kps_pkg::ST_BSW: state_next = kps_pkg::ST_BS;
            kps_pkg::ST_RA:  state_next = kps_pkg::ST_RB;
            kps_pkg::ST_RB:  state_next = kps_pkg::ST_RBW;
            kps_pkg::ST_RBW: state_next = kps_pkg::ST_ALPHA;
            kps_pkg::ST_ALPHA: begin
                state_next = (kb_reg.tm > ka_reg.tm && st_reg >= ka_reg.tm)
                             ? kps_pkg::ST_ALW : kps_pkg::ST_LMUL;
            end
            kps_pkg::ST_ALW: begin
                if (div_rsp.done) state_next = kps_pkg::ST_LMUL;
            end
            kps_pkg::ST_LMUL: state_next = kps_pkg::ST_LADD;
            kps_pkg::ST_LADD: begin
                state_next = (j_reg == 3'd7) ? kps_pkg::ST_SQMUL : kps_pkg::ST_LMUL;
            end
            kps_pkg::ST_SQMUL: state_next = kps_pkg::ST_SQADD;
            kps_pkg::ST_SQADD: begin
                state_next = (j_reg == 3'd2) ? kps_pkg::ST_NCHK : kps_pkg::ST_SQMUL;
            end
            kps_pkg::ST_NCHK: begin
                state_next = (acc_reg < 36'd3) ? kps_pkg::ST_DONE : kps_pkg::ST_SQRT;
            end
            kps_pkg::ST_SQRT: begin
                if (sbit_reg == 64'd0) state_next = kps_pkg::ST_LDIV;
            end
            kps_pkg::ST_LDIV: state_next = kps_pkg::ST_LDW;
            kps_pkg::ST_LDW: begin
                if (div_rsp.done) begin
                    state_next = (j_reg == 3'd2) ? kps_pkg::ST_DONE : kps_pkg::ST_LDIV;
                end
            end
            kps_pkg::ST_DONE: begin
                if (load_out) state_next = kps_pkg::ST_IDLE;
            end
            default: state_next = kps_pkg::ST_IDLE;
        endcase
    end

    // Datapath, table access and divider requests per state.
    always_comb begin
        cur_next      = cur_reg;
        playing_next  = playing_reg;
        tv_next       = tv_reg;
        st_next       = st_reg;
        idx_next      = idx_reg;
        scan_vld_next = scan_vld_reg;
        end_next      = end_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        ka_next       = ka_reg;
        kb_next       = kb_reg;
        alpha_next    = alpha_reg;
        j_next        = j_reg;
        prod_next     = prod_reg;
        lk_next       = lk_reg;
        acc_next      = acc_reg;
        sv_next       = sv_reg;
        sres_next     = sres_reg;
        sbit_next     = sbit_reg;
        rp_next       = rp_reg;
        rl_next       = rl_reg;
        rr_next       = rr_reg;
        rf_next       = rf_reg;
        hk_next       = hk_reg;
        ram_we        = 1'b0;
        ram_waddr     = AW'(s_key_index);
        ram_wdata     = {s_time_value, s_pos_x, s_pos_y, s_pos_z, s_look_x, s_look_y,
                         s_look_z, s_roll_angle, s_view_angle};
        ram_raddr     = '0;
        div_req       = '0;

        unique case (state_reg)
            // Accept an item; key writes finish here.
            kps_pkg::ST_IDLE: begin
                if (s_valid) begin
                    tv_next = s_time_value;
                    priority case (s_opcode)
                        kps_pkg::OP_WRITE: begin
                            ram_we = (32'(s_key_index) < 32'(MAX_KEYS));
                        end
                        kps_pkg::OP_SAMPLE: st_next = s_time_value;
                        kps_pkg::OP_TICK: begin
                            idx_next      = '0;
                            scan_vld_next = 1'b0;
                            end_next      = '0;
                        end
                        kps_pkg::OP_PLAY: begin
                            playing_next = 1'b1;
                            st_next      = cur_reg;
                        end
                        kps_pkg::OP_STOP: begin
                            playing_next = 1'b0;
                            cur_next     = '0;
                            st_next      = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // Largest key time, one entry per cycle.
            kps_pkg::ST_SCAN: begin
                if (scan_vld_reg && rd.tm > end_reg) end_next = rd.tm;
                if (idx_reg < n_keys) begin
                    ram_raddr     = AW'(idx_reg);
                    idx_next      = idx_reg + CW'(1);
                    scan_vld_next = 1'b1;
                end else begin
                    scan_vld_next = 1'b0;
                end
            end
            // Advance the playback time.
            kps_pkg::ST_TICK: begin
                cur_next = cur_c;
                st_next  = cur_c;
                if (playing_reg) begin
                    if (end_reg == 32'd0) begin
                        cur_next     = '0;
                        st_next      = '0;
                        playing_next = 1'b0;
                    end else if (tick_sum >= {1'b0, end_reg}) begin
                        if (loop_reg) begin
                            div_req.start = 1'b1;
                            div_req.numer = 48'(tick_sum);
                            div_req.denom = end_reg;
                        end else begin
                            cur_next     = end_reg;
                            st_next      = end_reg;
                            playing_next = 1'b0;
                        end
                    end else begin
                        cur_next = tick_sum[31:0];
                        st_next  = tick_sum[31:0];
                    end
                end
            end
            kps_pkg::ST_MODW: begin
                if (div_rsp.done) begin
                    cur_next = div_rsp.rem;
                    st_next  = div_rsp.rem;
                end
            end
            // Empty table check and first key read.
            kps_pkg::ST_SMP0: begin
                if (n_keys == '0) begin
                    hk_next = 1'b0;
                    rp_next = '{default: '0};
                    rl_next = '{default: '0};
                    rr_next = '0;
                    rf_next = '0;
                end else begin
                    hk_next = 1'b1;
                end
            end
            // Clamp to the first or the last key.
            kps_pkg::ST_SMP1, kps_pkg::ST_SMP2: begin
                rp_next[0] = rd.px;
                rp_next[1] = rd.py;
                rp_next[2] = rd.pz;
                rl_next[0] = rd.lx;
                rl_next[1] = rd.ly;
                rl_next[2] = rd.lz;
                rr_next    = rd.roll;
                rf_next    = rd.fov;
                ram_raddr  = AW'(n_keys - CW'(1));
                lo_next    = '0;
                hi_next    = n_keys;
            end
            // Binary search for the segment.
            kps_pkg::ST_BS: begin
                mid_next  = lohi[CW:1];
                ram_raddr = AW'(lohi[CW:1]);
                if (lo_reg >= hi_reg) begin
                    if (lo_reg < CW'(1)) begin
                        lo_next = CW'(1);
                    end else if (lo_reg > n_keys - CW'(1)) begin
                        lo_next = n_keys - CW'(1);
                    end
                end
            end
            kps_pkg::ST_BSW: begin
                if (st_reg < rd.tm) hi_next = mid_reg;
                else                lo_next = mid_reg + CW'(1);
            end
            kps_pkg::ST_RA: ram_raddr = AW'(lo_reg - CW'(1));
            kps_pkg::ST_RB: begin
                ram_raddr = AW'(lo_reg);
                ka_next   = rd;
            end
            kps_pkg::ST_RBW: kb_next = rd;
            // Alpha as a clamped Q1.16 ratio.
            kps_pkg::ST_ALPHA: begin
                j_next     = '0;
                alpha_next = '0;
                if (kb_reg.tm > ka_reg.tm && st_reg >= ka_reg.tm) begin
                    div_req.start = 1'b1;
                    div_req.numer = {st_reg - ka_reg.tm, 16'd0};
                    div_req.denom = kb_reg.tm - ka_reg.tm;
                end
            end
            kps_pkg::ST_ALW: begin
                if (div_rsp.done) begin
                    alpha_next = (div_rsp.quot > 48'(kps_pkg::ALPHA_ONE))
                                 ? kps_pkg::ALPHA_ONE : div_rsp.quot[16:0];
                end
            end
            // Linear interpolation, one component per multiply and add pass.
            kps_pkg::ST_LMUL: prod_next = mul_p;
            kps_pkg::ST_LADD: begin
                unique case (j_reg)
                    3'd0, 3'd1, 3'd2: begin
                        if (lerp_sum > 52'sd2147483647) begin
                            rp_next[j_reg[1:0]] = 32'sh7FFFFFFF;
                        end else if (lerp_sum < -52'sd2147483648) begin
                            rp_next[j_reg[1:0]] = 32'sh80000000;
                        end else begin
                            rp_next[j_reg[1:0]] = lerp_sum[31:0];
                        end
                    end
                    3'd3: lk_next[0] = lerp_sum[17:0];
                    3'd4: lk_next[1] = lerp_sum[17:0];
                    3'd5: lk_next[2] = lerp_sum[17:0];
                    3'd6: begin
                        if (lerp_sum > 52'sd32767)       rr_next = 16'sh7FFF;
                        else if (lerp_sum < -52'sd32768) rr_next = 16'sh8000;
                        else                             rr_next = lerp_sum[15:0];
                    end
                    default: begin
                        if (lerp_sum > 52'sd65535)  rf_next = 16'hFFFF;
                        else if (lerp_sum < 52'sd0) rf_next = 16'h0000;
                        else                        rf_next = lerp_sum[15:0];
                    end
                endcase
                j_next   = (j_reg == 3'd7) ? 3'd0 : j_reg + 3'd1;
                acc_next = '0;
            end
            // Squared length of the interpolated look.
            kps_pkg::ST_SQMUL: prod_next = mul_p;
            kps_pkg::ST_SQADD: begin
                acc_next = acc_reg + prod_reg[35:0];
                j_next   = (j_reg == 3'd2) ? 3'd0 : j_reg + 3'd1;
            end
            kps_pkg::ST_NCHK: begin
                rl_next[0] = '0;
                rl_next[1] = '0;
                rl_next[2] = $signed({1'b0, kps_pkg::LOOK_ONE});
                sv_next    = {acc_reg[35:0], 28'd0};
                sres_next  = '0;
                sbit_next  = 64'd1 << 62;
            end
            // Integer square root, two bits per cycle.
            kps_pkg::ST_SQRT: begin
                if (sbit_reg != 64'd0) begin
                    if (sv_reg >= sq_trial) begin
                        sv_next   = sv_reg - sq_trial;
                        sres_next = (sres_reg >> 1) + sbit_reg;
                    end else begin
                        sres_next = sres_reg >> 1;
                    end
                    sbit_next = sbit_reg >> 2;
                end
            end
            // Renormalize each look component by the root.
            kps_pkg::ST_LDIV: begin
                div_req.start = 1'b1;
                div_req.numer = {2'd0, mag, 28'd0};
                div_req.denom = sres_reg[31:0];
            end
            kps_pkg::ST_LDW: begin
                if (div_rsp.done) begin
                    rl_next[j_reg[1:0]] = lk_reg[j_reg[1:0]][17]
                                          ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
                    j_next = j_reg + 3'd1;
                end
            end
            kps_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // Result slot toward the consumer.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out)                    m_valid_next = 1'b1;
        else if (m_valid_reg && m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kps_pkg::ST_IDLE;
            cur_reg       <= '0;
            playing_reg   <= 1'b0;
            key_count_reg <= '0;
            loop_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            scan_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            playing_reg  <= playing_next;
            m_valid_reg  <= m_valid_next;
            scan_vld_reg <= scan_vld_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == kps_pkg::REG_KEY_COUNT) key_count_reg <= cfg_data[6:0];
                if (cfg_index == kps_pkg::REG_LOOP)      loop_reg      <= cfg_data[0];
            end
        end
        tv_reg    <= tv_next;
        st_reg    <= st_next;
        idx_reg   <= idx_next;
        end_reg   <= end_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        ka_reg    <= ka_next;
        kb_reg    <= kb_next;
        alpha_reg <= alpha_next;
        j_reg     <= j_next;
        prod_reg  <= prod_next;
        lk_reg    <= lk_next;
        acc_reg   <= acc_next;
        sv_reg    <= sv_next;
        sres_reg  <= sres_next;
        sbit_reg  <= sbit_next;
        rp_reg    <= rp_next;
        rl_reg    <= rl_next;
        rr_reg    <= rr_next;
        rf_reg    <= rf_next;
        hk_reg    <= hk_next;
        if (load_out) begin
            m_out_pos_x  <= rp_reg[0];
            m_out_pos_y  <= rp_reg[1];
            m_out_pos_z  <= rp_reg[2];
            m_out_look_x <= rl_reg[0];
            m_out_look_y <= rl_reg[1];
            m_out_look_z <= rl_reg[2];
            m_out_roll   <= rr_reg;
            m_out_fov    <= rf_reg;
            m_play_time  <= cur_reg;
            m_is_playing <= playing_reg;
            m_has_keys   <= hk_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/kps_check.sv]
// Port-level checks of the keyframe playback sampler, bound to the top level.
`default_nettype none

module kps_check (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [2:0]         s_opcode,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_has_keys,
    input wire logic signed [31:0] m_out_pos_x,
    input wire logic signed [31:0] m_out_pos_y,
    input wire logic signed [31:0] m_out_pos_z,
    input wire logic signed [15:0] m_out_look_x,
    input wire logic signed [15:0] m_out_look_y,
    input wire logic signed [15:0] m_out_look_z,
    input wire logic signed [15:0] m_out_roll,
    input wire logic [15:0]        m_out_fov
);

    // A waiting result stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    // Reset leaves no result offered.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // An empty table yields an all-zero pose.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_keys |-> (m_out_pos_x == 0) && (m_out_pos_y == 0) &&
        (m_out_pos_z == 0) && (m_out_look_x == 0) && (m_out_look_y == 0) &&
        (m_out_look_z == 0) && (m_out_roll == 0) && (m_out_fov == 0))
        else $error("pose not zero for an empty table");

    // A sample item keeps the block busy in the following cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == kps_pkg::OP_SAMPLE) |=> !s_ready)
        else $error("ready right after a sample item");

endmodule

bind keyframe_playback_sampler kps_check u_kps_check (.*);

`default_nettype wire
